>>> src/lbec_pkg.sv
// Shared types, constants and lookup tables for the lamp button/effect controller.
// No dependencies; every other file in src imports this package.
`default_nettype none

package lbec_pkg;

   // Step counts of the selection wheels
   localparam int HUE_STEPS    = 33;
   localparam int EFFECT_COUNT = 6;
   localparam int SPEED_STEPS  = 6;
   localparam int SAT_STEPS    = 5;
   localparam int LIGHT_STEPS  = 5;

   // Reset selections
   localparam logic [5:0] HUE_RESET   = (HUE_STEPS > 14) ? 6'd14 : 6'd0;
   localparam logic [2:0] SAT_RESET   = 3'd4;
   localparam logic [2:0] LIGHT_RESET = 3'd2;
   localparam logic [2:0] SPEED_RESET = (SPEED_STEPS > 3) ? 3'd3 : 3'd0;

   // Glow limits in hundredths
   localparam int GLOW_MIN_HI = 15;
   localparam int GLOW_MAX_HI = 45;

   // Random hue remainder: q = (x * HUE_RECIP) >> HUE_RECIP_SHIFT is the exact quotient
   // for every 16-bit x and any hue count up to 64
   localparam int HUE_RECIP_SHIFT = 23;
   localparam int HUE_RECIP       = (2 ** HUE_RECIP_SHIFT + HUE_STEPS - 1) / HUE_STEPS;

   // Effect codes
   localparam logic [2:0] EFF_NONE        = 3'd0;
   localparam logic [2:0] EFF_GLOW        = 3'd1;
   localparam logic [2:0] EFF_GLOW_BLACK  = 3'd2;
   localparam logic [2:0] EFF_BLINK       = 3'd3;
   localparam logic [2:0] EFF_BLINK_BLACK = 3'd4;
   localparam logic [2:0] EFF_RANDOM      = 3'd5;

   // CSR indexes
   localparam logic [1:0] CSR_PRESS_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_BLINK_DARK      = 2'd1;
   localparam logic [1:0] CSR_ROLL_INTERVAL   = 2'd2;
   localparam logic [1:0] CSR_ROLL_TARGET     = 2'd3;

   // Shared divider widths
   localparam int DIV_W  = 32;
   localparam int DVSR_W = 20;

   typedef struct packed {
      logic [9:0]  hue_button_level;
      logic [9:0]  light_button_level;
      logic [9:0]  effect_button_level;
      logic [31:0] time_ms;
      logic [15:0] roll_random;
      logic [15:0] hue_random;
   } req_type;

   typedef struct packed {
      logic [5:0]  out_hue;
      logic [2:0]  out_sat;
      logic [10:0] out_lightness;
      logic [2:0]  out_effect;
      logic [2:0]  out_speed;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  press_threshold;
      logic [15:0] blink_dark_ms;
      logic [15:0] roll_interval_ms;
      logic [8:0]  roll_target;
   } cfg_type;

   // Work handed from front to back
   typedef struct packed {
      logic [5:0]  hue;
      logic [2:0]  sat;
      logic [2:0]  light;
      logic [2:0]  effect;
      logic [2:0]  speed;
      logic        roll;
      logic [31:0] time_ms;
      logic [15:0] roll_random;
      logic [15:0] hue_random;
   } job_type;

   // Hue write-back after a roll
   typedef struct packed {
      logic       valid;
      logic [5:0] hue;
   } wb_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [DVSR_W-1:0] remainder;
   } div_rsp_type;

   // Effect period per speed; saturates at the last entry
   function automatic logic [13:0] period_ms(input logic [2:0] speed);
      logic [13:0] p;
      case (speed)
         3'd0:    p = 14'd1000;
         3'd1:    p = 14'd2000;
         3'd2:    p = 14'd3500;
         3'd3:    p = 14'd5000;
         3'd4:    p = 14'd7500;
         default: p = 14'd10000;
      endcase
      return p;
   endfunction

   // 100 * period, glow divisor
   function automatic logic [19:0] period_den(input logic [2:0] speed);
      logic [19:0] d;
      case (speed)
         3'd0:    d = 20'd100000;
         3'd1:    d = 20'd200000;
         3'd2:    d = 20'd350000;
         3'd3:    d = 20'd500000;
         3'd4:    d = 20'd750000;
         default: d = 20'd1000000;
      endcase
      return d;
   endfunction

   // 50 * period, rounding bias of the glow division
   function automatic logic [18:0] period_half(input logic [2:0] speed);
      logic [18:0] h;
      case (speed)
         3'd0:    h = 19'd50000;
         3'd1:    h = 19'd100000;
         3'd2:    h = 19'd175000;
         3'd3:    h = 19'd250000;
         3'd4:    h = 19'd375000;
         default: h = 19'd500000;
      endcase
      return h;
   endfunction

   // 3% of the period, roll range
   function automatic logic [8:0] roll_limit(input logic [2:0] speed);
      logic [8:0] l;
      case (speed)
         3'd0:    l = 9'd30;
         3'd1:    l = 9'd60;
         3'd2:    l = 9'd105;
         3'd3:    l = 9'd150;
         3'd4:    l = 9'd225;
         default: l = 9'd300;
      endcase
      return l;
   endfunction

   // Lightness table in Q10
   function automatic logic [10:0] light_q10(input logic [2:0] idx);
      logic [10:0] v;
      case (idx)
         3'd0:    v = 11'd164;
         3'd1:    v = 11'd338;
         3'd2:    v = 11'd512;
         3'd3:    v = 11'd768;
         default: v = 11'd1024;
      endcase
      return v;
   endfunction

   // Quarter lightness, dark phase of plain blink
   function automatic logic [10:0] light_dim_q10(input logic [2:0] idx);
      logic [10:0] v;
      case (idx)
         3'd0:    v = 11'd41;
         3'd1:    v = 11'd84;
         3'd2:    v = 11'd128;
         3'd3:    v = 11'd192;
         default: v = 11'd256;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> src/lbec_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on lbec_pkg (widths and request/response structs).
`default_nettype none

module lbec_div (
   input  wire                       clock,
   input  wire                       reset,
   input  lbec_pkg::div_req_type     div_req,
   output lbec_pkg::div_rsp_type     div_rsp
);
   import lbec_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVSR_W:0]   trial;
   logic [DVSR_W:0]   diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      ge      = (trial >= {1'b0, dvsr_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvsr_in = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      cnt_ff  <= cnt_in;
      busy_ff <= busy_in;
      done_ff <= done_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

>>> src/lbec_fifo.sv
// Two-entry job queue between front and back.
// Depends on lbec_pkg (job_type).
`default_nettype none

module lbec_fifo (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  lbec_pkg::job_type    wr_data,
   input  wire                  pop,
   output lbec_pkg::job_type    rd_data,
   output logic                 full,
   output logic                 empty
);
   import lbec_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      count_ff  <= count_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end
   end

   assign rd_data = entry_ff[rd_ptr_ff];
   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);

endmodule

`default_nettype wire

>>> src/lbec_front.sv
// Front end: takes requests, decodes button edges and combos, holds the selections,
// decides on a colour roll and queues the job. Depends on lbec_pkg.
`default_nettype none

module lbec_front (
   input  wire                  clock,
   input  wire                  reset,
   input  lbec_pkg::cfg_type    cfg,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  lbec_pkg::req_type    req_data,
   input  wire                  q_full,
   output logic                 q_push,
   output lbec_pkg::job_type    q_data,
   input  lbec_pkg::wb_type     wb
);
   import lbec_pkg::*;

   logic [5:0]  hue_ff, hue_in;
   logic [2:0]  sat_ff, sat_in;
   logic [2:0]  light_ff, light_in;
   logic [2:0]  effect_ff, effect_in;
   logic [2:0]  speed_ff, speed_in;
   logic [2:0]  prev_held_ff, prev_held_in;
   logic [2:0]  cancel_ff, cancel_in;
   logic [31:0] last_roll_ff, last_roll_in;
   logic        hue_wait_ff, hue_wait_in;

   logic        accept;
   logic [2:0]  held, rel;
   logic [9:0]  lv [3];
   logic        roll;
   logic [31:0] since_roll;
   logic [6:0]  hue_inc;
   logic [3:0]  sat_inc, light_inc, effect_inc, speed_inc;

   assign req_stall = q_full | hue_wait_ff;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      lv[0] = req_data.hue_button_level;
      lv[1] = req_data.light_button_level;
      lv[2] = req_data.effect_button_level;
      for (int i = 0; i < 3; i++) begin
         held[i] = lv[i] > cfg.press_threshold;
         rel[i]  = lv[i] < cfg.press_threshold;
      end

      hue_inc    = {1'b0, hue_ff} + 7'd1;
      sat_inc    = {1'b0, sat_ff} + 4'd1;
      light_inc  = {1'b0, light_ff} + 4'd1;
      effect_inc = {1'b0, effect_ff} + 4'd1;
      speed_inc  = {1'b0, speed_ff} + 4'd1;

      hue_in       = hue_ff;
      sat_in       = sat_ff;
      light_in     = light_ff;
      effect_in    = effect_ff;
      speed_in     = speed_ff;
      cancel_in    = cancel_ff;
      prev_held_in = prev_held_ff;
      last_roll_in = last_roll_ff;
      hue_wait_in  = hue_wait_ff;
      roll         = 1'b0;
      since_roll   = req_data.time_ms - last_roll_ff;

      if (accept) begin
         // first matching rule wins
         if (held[0] && prev_held_ff[1] && rel[1]) begin
            cancel_in[0] = 1'b1;
            sat_in = (sat_inc >= 4'(SAT_STEPS)) ? 3'd0 : sat_inc[2:0];
         end else if (held[2] && prev_held_ff[1] && rel[1]) begin
            cancel_in[2] = 1'b1;
            speed_in = (speed_inc >= 4'(SPEED_STEPS)) ? 3'd0 : speed_inc[2:0];
         end else if (rel[0] && prev_held_ff[0]) begin
            if (cancel_ff[0]) cancel_in[0] = 1'b0;
            else hue_in = (hue_inc >= 7'(HUE_STEPS)) ? 6'd0 : hue_inc[5:0];
         end else if (rel[1] && prev_held_ff[1]) begin
            if (cancel_ff[1]) cancel_in[1] = 1'b0;
            else light_in = (light_inc >= 4'(LIGHT_STEPS)) ? 3'd0 : light_inc[2:0];
         end else if (rel[2] && prev_held_ff[2]) begin
            if (cancel_ff[2]) cancel_in[2] = 1'b0;
            else effect_in = (effect_inc >= 4'(EFFECT_COUNT)) ? 3'd0 : effect_inc[2:0];
         end
         prev_held_in = held;

         roll = (effect_in == EFF_RANDOM) && (since_roll > {16'd0, cfg.roll_interval_ms});
         if (roll) begin
            last_roll_in = req_data.time_ms;
            hue_wait_in  = 1'b1;   // hue may change; hold off until back reports it
         end
      end else if (wb.valid) begin
         hue_in      = wb.hue;
         hue_wait_in = 1'b0;
      end

      q_data.hue         = hue_in;
      q_data.sat         = sat_in;
      q_data.light       = light_in;
      q_data.effect      = effect_in;
      q_data.speed       = speed_in;
      q_data.roll        = roll;
      q_data.time_ms     = req_data.time_ms;
      q_data.roll_random = req_data.roll_random;
      q_data.hue_random  = req_data.hue_random;
   end

   assign q_push = accept;

   always_ff @(posedge clock) begin
      hue_ff       <= hue_in;
      sat_ff       <= sat_in;
      light_ff     <= light_in;
      effect_ff    <= effect_in;
      speed_ff     <= speed_in;
      prev_held_ff <= prev_held_in;
      cancel_ff    <= cancel_in;
      last_roll_ff <= last_roll_in;
      hue_wait_ff  <= hue_wait_in;
      if (reset) begin
         hue_ff       <= HUE_RESET;
         sat_ff       <= SAT_RESET;
         light_ff     <= LIGHT_RESET;
         effect_ff    <= EFF_NONE;
         speed_ff     <= SPEED_RESET;
         prev_held_ff <= '0;
         cancel_ff    <= '0;
         last_roll_ff <= '0;
         hue_wait_ff  <= 1'b0;
      end
   end

endmodule

`default_nettype wire

>>> src/lbec_back.sv
// Back end: pulls jobs, works out lightness (table, glow, blink) with the shared divider
// and the random hue by reciprocal multiply, and holds the response register. Depends on lbec_pkg.
`default_nettype none

module lbec_back (
   input  wire                    clock,
   input  wire                    reset,
   input  lbec_pkg::cfg_type      cfg,
   input  wire                    q_empty,
   input  lbec_pkg::job_type      q_data,
   output logic                   q_pop,
   output lbec_pkg::div_req_type  div_req,
   input  lbec_pkg::div_rsp_type  div_rsp,
   output lbec_pkg::wb_type       wb,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output lbec_pkg::rsp_type      rsp_data
);
   import lbec_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_T,
      ST_DIV_GLOW,
      ST_DIV_ROLL,
      ST_HUE_MOD,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic              div_start_ff, div_start_in;
   logic [DIV_W-1:0]  dividend_ff, dividend_in;
   logic [DVSR_W-1:0] divisor_ff, divisor_in;
   logic [10:0]       light_ff, light_in;
   logic [5:0]        hue_ff, hue_in;
   logic              wb_valid_ff, wb_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [15:0]       hue_quo_ff, hue_quo_in;

   logic [13:0]       p_new, p_job;
   logic [13:0]       r;
   logic [14:0]       twice_r, d;
   logic [5:0]        min_w, span_w;
   logic [18:0]       x;
   logic [5:0]        hue_rem;

   always_comb begin
      p_new   = period_ms(q_data.speed);
      p_job   = period_ms(job_ff.speed);
      r       = div_rsp.remainder[13:0];
      twice_r = {r, 1'b0};
      d       = (twice_r >= {1'b0, p_job}) ? twice_r - {1'b0, p_job}
                                           : {1'b0, p_job} - twice_r;
      min_w   = (job_ff.effect == EFF_GLOW) ? 6'(GLOW_MIN_HI) : 6'd0;
      span_w  = 6'(GLOW_MAX_HI) - min_w;
      x       = 19'(min_w * p_job) + 19'(span_w * d);

      // hue_random / HUE_STEPS, registered; job_ff is steady long before it is needed
      hue_quo_in = 16'((39'(job_ff.hue_random) * 39'(HUE_RECIP)) >> HUE_RECIP_SHIFT);
      hue_rem    = 6'(job_ff.hue_random - 16'(hue_quo_ff * HUE_STEPS));

      state_in     = state_ff;
      job_in       = job_ff;
      div_start_in = 1'b0;
      dividend_in  = dividend_ff;
      divisor_in   = divisor_ff;
      light_in     = light_ff;
      hue_in       = hue_ff;
      wb_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_data;
               hue_in   = q_data.hue;
               light_in = light_q10(q_data.light);
               if (q_data.effect == EFF_GLOW || q_data.effect == EFF_GLOW_BLACK) begin
                  dividend_in  = q_data.time_ms;
                  divisor_in   = DVSR_W'(p_new);
                  div_start_in = 1'b1;
                  state_in     = ST_DIV_T;
               end else if (q_data.effect inside {EFF_BLINK, EFF_BLINK_BLACK}) begin
                  dividend_in  = q_data.time_ms;
                  divisor_in   = DVSR_W'(p_new) + DVSR_W'(cfg.blink_dark_ms);
                  div_start_in = 1'b1;
                  state_in     = ST_DIV_T;
               end else if (q_data.effect == EFF_RANDOM && q_data.roll) begin
                  dividend_in  = DIV_W'(q_data.roll_random);
                  divisor_in   = DVSR_W'(roll_limit(q_data.speed));
                  div_start_in = 1'b1;
                  state_in     = ST_DIV_ROLL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV_T: begin
            if (div_rsp.done) begin
               if (job_ff.effect == EFF_GLOW || job_ff.effect == EFF_GLOW_BLACK) begin
                  // round(1024 * x / (100 P)), half up
                  dividend_in  = {3'd0, x, 10'd0} + DIV_W'(period_half(job_ff.speed));
                  divisor_in   = period_den(job_ff.speed);
                  div_start_in = 1'b1;
                  state_in     = ST_DIV_GLOW;
               end else begin
                  if (div_rsp.remainder >= DVSR_W'(p_job)) begin
                     light_in = (job_ff.effect == EFF_BLINK) ? light_dim_q10(job_ff.light)
                                                             : 11'd0;
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV_GLOW: begin
            if (div_rsp.done) begin
               light_in = div_rsp.quotient[10:0];
               state_in = ST_DONE;
            end
         end
         ST_DIV_ROLL: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == DVSR_W'(cfg.roll_target)) begin
                  state_in = ST_HUE_MOD;
               end else begin
                  wb_valid_in = 1'b1;
                  state_in    = ST_DONE;
               end
            end
         end
         ST_HUE_MOD: begin
            hue_in      = hue_rem;
            wb_valid_in = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_hue       = hue_ff;
               rsp_data_in.out_sat       = job_ff.sat;
               rsp_data_in.out_lightness = light_ff;
               rsp_data_in.out_effect    = job_ff.effect;
               rsp_data_in.out_speed     = job_ff.speed;
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff     <= state_in;
      job_ff       <= job_in;
      div_start_ff <= div_start_in;
      dividend_ff  <= dividend_in;
      divisor_ff   <= divisor_in;
      light_ff     <= light_in;
      hue_ff       <= hue_in;
      wb_valid_ff  <= wb_valid_in;
      rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff  <= rsp_data_in;
      hue_quo_ff   <= hue_quo_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_start_ff <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign div_req.start    = div_start_ff;
   assign div_req.dividend = dividend_ff;
   assign div_req.divisor  = divisor_ff;
   assign wb.valid         = wb_valid_ff;
   assign wb.hue           = hue_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/lamp_button_effect_controller_unit.sv
// Top level of the lamp button/effect controller: CSRs, front, job queue, back, divider.
// Depends on lbec_pkg, lbec_front, lbec_fifo, lbec_back, lbec_div.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  req_    | in        | req_valid / req_stall  | lbec_pkg::req_type (one tick)
//  rsp_    | out       | rsp_valid / rsp_stall  | lbec_pkg::rsp_type (one per request)
//  csr_    | in        | csr_valid / csr_ready  | csr_index (2b), csr_data (16b)
//
// Work per request in the back end: table lightness takes no division, blink or a roll
// takes one (a roll that hits adds a hue step), glow takes two; each division runs
// through the shared 32-step divider, one quotient bit per cycle.
// Reset is synchronous and active high; selections return to their defaults.
// req_stall rises when the two-entry job queue is full, and after a request that
// rolls the colour until the back end has returned the new hue.
// A stalled response register holds; the front keeps accepting into the queue meanwhile.
`default_nettype none

module lamp_button_effect_controller_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  lbec_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output lbec_pkg::rsp_type    rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire  [1:0]           csr_index,
   input  wire  [15:0]          csr_data
);
   import lbec_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_pop, q_full, q_empty;
   job_type     q_wr_data, q_rd_data;
   wb_type      wb;
   div_req_type div_req;
   div_rsp_type div_rsp;

   // CSR writes are always accepted and registered straight into cfg
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PRESS_THRESHOLD: cfg_in.press_threshold  = csr_data[9:0];
            CSR_BLINK_DARK:      cfg_in.blink_dark_ms    = csr_data;
            CSR_ROLL_INTERVAL:   cfg_in.roll_interval_ms = csr_data;
            CSR_ROLL_TARGET:     cfg_in.roll_target      = csr_data[8:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
      if (reset) begin
         cfg_ff.press_threshold  <= 10'd800;
         cfg_ff.blink_dark_ms    <= 16'd500;
         cfg_ff.roll_interval_ms <= 16'd1000;
         cfg_ff.roll_target      <= 9'd11;
      end
   end

   // Front: edge/combo decode and selection state
   lbec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr_data),
      .wb        (wb)
   );

   // Job queue decouples decode from the divider work
   lbec_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   // Back: lightness and roll, owns the response register
   lbec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .wb        (wb),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   lbec_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Lightness never exceeds 1.0 in Q10
   a_light_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.out_lightness <= 11'd1024))
      else $error("lightness out of range");

   // Selections stay inside their wheels
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.out_hue} < 7'(HUE_STEPS)) &&
                    ({1'b0, rsp_data.out_sat} < 4'(SAT_STEPS)) &&
                    ({1'b0, rsp_data.out_effect} < 4'(EFFECT_COUNT)) &&
                    ({1'b0, rsp_data.out_speed} < 4'(SPEED_STEPS)))
      else $error("selection out of range");

   // A hue write-back only arrives while the front is holding off requests
   a_wb_while_stalled: assert property (@(posedge clock) disable iff (reset)
      wb.valid |-> req_stall)
      else $error("hue write-back without pending roll");

   // A roll hold-off is cleared by the write-back the cycle after it
   a_wb_releases: assert property (@(posedge clock) disable iff (reset)
      wb.valid && !q_full |=> !req_stall)
      else $error("roll hold-off not released");

endmodule

`default_nettype wire
